>>> hdl/tars_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_pkg: shared types and constants of the triangle axis rotation sweep
// Widths, register indexes, axis codes, sequencer states and the sine table
// generator used by the rotation datapath.
// ----------------------------------------------------------------------------
package tars_pkg;

  // defaults for the top level parameters
  localparam int MaxSteps       = 64;
  localparam int CoordWidth     = 16;
  localparam int SineTableDepth = 256;

  // fixed field widths
  localparam int CountWidth = 7;
  localparam int AngleWidth = 16;
  localparam int TimeWidth  = 16;
  localparam int CfgWidth   = 16;
  localparam int TabWidth   = 15;
  localparam int TrigWidth  = 17;
  localparam int FracBits   = 15;
  localparam int RoundBias  = 1 << (FracBits - 1);

  // register indexes on the configuration port
  localparam logic [1:0] CfgAxisSelect = 2'd0;
  localparam logic [1:0] CfgStepCount  = 2'd1;
  localparam logic [1:0] CfgAngleStep  = 2'd2;
  localparam logic [1:0] CfgTimeStep   = 2'd3;

  // register reset values
  localparam logic [1:0]            AxisReset      = 2'd0;
  localparam logic [CountWidth-1:0] StepCountReset = 7'd16;
  localparam logic [AngleWidth-1:0] AngleStepReset = 16'd4369;
  localparam logic [TimeWidth-1:0]  TimeStepReset  = 16'd0;

  // axis codes, the unused code rotates about x
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  // coordinate slots inside one vertex
  localparam logic [1:0] CoordX = 2'd0;
  localparam logic [1:0] CoordY = 2'd1;
  localparam logic [1:0] CoordZ = 2'd2;

  // quarter turn added to get the cosine from the sine table
  localparam logic [AngleWidth-1:0] QuarterTurn = 16'h4000;

  // rotation pass: 12 products, last step only drains the accumulator
  localparam logic [3:0] RotLast = 4'd12;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIN,
    ST_COS,
    ST_CWAIT,
    ST_ROT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_first;
  } mac_ctrl_t;

  // sine of a Q30 phase through a seven term series, scaled to Q1.15
  function automatic logic [TabWidth-1:0] sine_from_x(input logic [63:0] x);
    logic [63:0] term;
    longint      sum;
    longint      scaled;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    scaled = (sum * 32767 + (longint'(1) <<< 29)) >>> 30;
    if (scaled > 32767) begin
      scaled = 32767;
    end
    return scaled[TabWidth-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/tars_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_sine_rom: quarter-wave sine lookup
// Maps a 16-bit angle to a signed Q1.15 sine through a quarter-wave table,
// with a registered read.
// ----------------------------------------------------------------------------
module tars_sine_rom #(
  parameter int SINE_TABLE_DEPTH = tars_pkg::SineTableDepth
) (
  input  wire logic                                  clk,
  input  wire logic [tars_pkg::AngleWidth-1:0]       angle,
  output logic signed [tars_pkg::TrigWidth-1:0]      value
);

  localparam int IdxW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PhaseW = tars_pkg::AngleWidth - 2;
  localparam int ProdW  = PhaseW + IdxW;

  logic [tars_pkg::TabWidth-1:0] tab [SINE_TABLE_DEPTH+1];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] PhaseQ30 =
      (tars_pkg::HalfPiQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    assign tab[k] = tars_pkg::sine_from_x(PhaseQ30);
  end

  logic [1:0]                    quadrant;
  logic [PhaseW-1:0]             phase;
  logic [ProdW-1:0]              scaled;
  logic [IdxW-1:0]               j;
  logic [IdxW-1:0]               addr;
  logic [tars_pkg::TabWidth-1:0] mag;

  assign quadrant = angle[tars_pkg::AngleWidth-1 -: 2];
  assign phase    = angle[PhaseW-1:0];
  assign scaled   = ProdW'(phase) * ProdW'(SINE_TABLE_DEPTH);
  assign j        = scaled[ProdW-1:PhaseW];
  // odd quadrants read the table backwards
  assign addr     = quadrant[0] ? (IdxW'(SINE_TABLE_DEPTH) - j) : j;
  assign mag      = tab[addr];

  always_ff @(posedge clk) begin
    if (quadrant[1]) begin
      value <= -signed'({2'b00, mag});
    end else begin
      value <= signed'({2'b00, mag});
    end
  end

endmodule
`default_nettype wire

>>> hdl/tars_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tars_mac: shared multiply-accumulate unit
// One coordinate times one Q1.15 factor per cycle while mul_en is set; pairs
// of products are summed, rounded half up and saturated to the coordinate range.
// ----------------------------------------------------------------------------
module tars_mac #(
  parameter int COORD_WIDTH = tars_pkg::CoordWidth
) (
  input  wire logic                                clk,
  input  wire tars_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [COORD_WIDTH-1:0]       coord,
  input  wire logic signed [tars_pkg::TrigWidth-1:0] factor,
  output logic signed [COORD_WIDTH-1:0]            result,
  output logic                                     result_valid
);

  localparam int ProdW = COORD_WIDTH + tars_pkg::TrigWidth;
  localparam int AccW  = ProdW + 1;
  localparam longint SatHiL = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint SatLoL = -SatHiL - 1;
  localparam logic signed [AccW-1:0] SatHi = AccW'(SatHiL);
  localparam logic signed [AccW-1:0] SatLo = AccW'(SatLoL);
  localparam logic signed [AccW-1:0] Bias  = AccW'(tars_pkg::RoundBias);

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  sum;
  logic signed [AccW-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coord * factor;
    end
    if (ctrl.acc_en && ctrl.acc_first) begin
      acc <= prod_ext + Bias;
    end
  end

  assign prod_ext = {prod[ProdW-1], prod};
  assign sum      = acc + prod_ext;
  assign shifted  = sum >>> tars_pkg::FracBits;

  always_comb begin
    if (shifted > SatHi) begin
      result = SatHi[COORD_WIDTH-1:0];
    end else if (shifted < SatLo) begin
      result = SatLo[COORD_WIDTH-1:0];
    end else begin
      result = shifted[COORD_WIDTH-1:0];
    end
  end

  assign result_valid = ctrl.acc_en && !ctrl.acc_first;

endmodule
`default_nettype wire

>>> hdl/triangle_axis_rotation_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a taken triangle goes through ST_SIN, ST_COS, ST_CWAIT and ST_ROT,
// then its first word is offered in ST_EMIT. Each rotated copy repeats these
// states, ST_EMIT holding while the output is stalled; the next triangle is
// taken only in ST_IDLE after the last of n copies, n = step_count kept within
// 2..MAX_STEPS (16 at reset). The single multiplier does twelve products per
// copy and the single sine table port is read twice per copy.
// Reset: sequencer idle, registers back to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
// triangle_axis_rotation_sweep: rotated copies of a triangle about one axis
// Sequencer around a shared multiply-accumulate unit and a sine table; each
// accepted triangle yields clamped step_count words with growing angle and time.
// ----------------------------------------------------------------------------
module triangle_axis_rotation_sweep #(
  parameter int MAX_STEPS        = tars_pkg::MaxSteps,
  parameter int COORD_WIDTH      = tars_pkg::CoordWidth,
  parameter int SINE_TABLE_DEPTH = tars_pkg::SineTableDepth
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [tars_pkg::CfgWidth-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]       v0_x,
  input  wire logic signed [COORD_WIDTH-1:0]       v0_y,
  input  wire logic signed [COORD_WIDTH-1:0]       v0_z,
  input  wire logic signed [COORD_WIDTH-1:0]       v1_x,
  input  wire logic signed [COORD_WIDTH-1:0]       v1_y,
  input  wire logic signed [COORD_WIDTH-1:0]       v1_z,
  input  wire logic signed [COORD_WIDTH-1:0]       v2_x,
  input  wire logic signed [COORD_WIDTH-1:0]       v2_y,
  input  wire logic signed [COORD_WIDTH-1:0]       v2_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [COORD_WIDTH-1:0]            r0_x,
  output logic signed [COORD_WIDTH-1:0]            r0_y,
  output logic signed [COORD_WIDTH-1:0]            r0_z,
  output logic signed [COORD_WIDTH-1:0]            r1_x,
  output logic signed [COORD_WIDTH-1:0]            r1_y,
  output logic signed [COORD_WIDTH-1:0]            r1_z,
  output logic signed [COORD_WIDTH-1:0]            r2_x,
  output logic signed [COORD_WIDTH-1:0]            r2_y,
  output logic signed [COORD_WIDTH-1:0]            r2_z,
  output logic [tars_pkg::TimeWidth-1:0]           time_value,
  output logic                                     last_copy
);

  localparam int CW = tars_pkg::CountWidth;
  localparam logic [CW-1:0] MinSteps = CW'(2);
  localparam logic [CW-1:0] MaxStepsC = CW'(MAX_STEPS);

  // configuration registers
  logic [1:0]                        axis_select;
  logic [CW-1:0]                     step_count;
  logic [tars_pkg::AngleWidth-1:0]   angle_step;
  logic [tars_pkg::TimeWidth-1:0]    time_step;

  // working state
  tars_pkg::state_t                  state;
  tars_pkg::state_t                  state_next;
  logic signed [COORD_WIDTH-1:0]     held [9];
  logic signed [COORD_WIDTH-1:0]     res [9];
  logic [CW-1:0]                     copy_index;
  logic [CW-1:0]                     copies;
  logic [tars_pkg::AngleWidth-1:0]   angle_accum;
  logic [tars_pkg::TimeWidth-1:0]    time_accum;
  logic [3:0]                        step;
  logic signed [tars_pkg::TrigWidth-1:0] sin_val;
  logic signed [tars_pkg::TrigWidth-1:0] cos_val;

  logic                              in_take;
  logic                              out_take;
  logic [CW-1:0]                     copies_clamped;

  // rotation plane: a' = c*a - s*b, b' = s*a + c*b, the axis coordinate passes
  logic [1:0]                        coord_a;
  logic [1:0]                        coord_b;
  logic [1:0]                        coord_p;

  logic [tars_pkg::AngleWidth-1:0]   rom_angle;
  logic signed [tars_pkg::TrigWidth-1:0] rom_value;

  tars_pkg::mac_ctrl_t               mac_ctrl;
  logic [3:0]                        wstep;
  logic [1:0]                        mul_vtx;
  logic [1:0]                        mul_coord;
  logic [3:0]                        mul_idx;
  logic [1:0]                        wr_vtx;
  logic [1:0]                        wr_coord;
  logic [3:0]                        wr_idx;
  logic signed [COORD_WIDTH-1:0]     mac_coord;
  logic signed [tars_pkg::TrigWidth-1:0] mac_factor;
  logic signed [COORD_WIDTH-1:0]     mac_result;
  logic                              mac_valid;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    if (step_count < MinSteps) begin
      copies_clamped = MinSteps;
    end else if (step_count > MaxStepsC) begin
      copies_clamped = MaxStepsC;
    end else begin
      copies_clamped = step_count;
    end
  end

  always_comb begin
    case (axis_select)
      tars_pkg::AxisY: begin
        coord_a = tars_pkg::CoordZ;
        coord_b = tars_pkg::CoordX;
        coord_p = tars_pkg::CoordY;
      end
      tars_pkg::AxisZ: begin
        coord_a = tars_pkg::CoordX;
        coord_b = tars_pkg::CoordY;
        coord_p = tars_pkg::CoordZ;
      end
      default: begin
        coord_a = tars_pkg::CoordY;
        coord_b = tars_pkg::CoordZ;
        coord_p = tars_pkg::CoordX;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_select <= tars_pkg::AxisReset;
      step_count  <= tars_pkg::StepCountReset;
      angle_step  <= tars_pkg::AngleStepReset;
      time_step   <= tars_pkg::TimeStepReset;
    end else if (cfg_write) begin
      case (cfg_index)
        tars_pkg::CfgAxisSelect: axis_select <= cfg_data[1:0];
        tars_pkg::CfgStepCount:  step_count  <= cfg_data[CW-1:0];
        tars_pkg::CfgAngleStep:  angle_step  <= cfg_data[tars_pkg::AngleWidth-1:0];
        tars_pkg::CfgTimeStep:   time_step   <= cfg_data[tars_pkg::TimeWidth-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tars_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      tars_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = tars_pkg::ST_SIN;
        end
      end
      tars_pkg::ST_SIN:   state_next = tars_pkg::ST_COS;
      tars_pkg::ST_COS:   state_next = tars_pkg::ST_CWAIT;
      tars_pkg::ST_CWAIT: state_next = tars_pkg::ST_ROT;
      tars_pkg::ST_ROT: begin
        if (step == tars_pkg::RotLast) begin
          state_next = tars_pkg::ST_EMIT;
        end
      end
      tars_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = last_copy ? tars_pkg::ST_IDLE : tars_pkg::ST_SIN;
        end
      end
      default: state_next = tars_pkg::ST_IDLE;
    endcase
  end

  // counters and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_index  <= '0;
      copies      <= MinSteps;
      angle_accum <= '0;
      time_accum  <= '0;
      step        <= '0;
    end else begin
      if (in_take) begin
        copy_index  <= '0;
        copies      <= copies_clamped;
        angle_accum <= '0;
        time_accum  <= '0;
      end else if (out_take) begin
        copy_index  <= copy_index + CW'(1);
        angle_accum <= angle_accum + angle_step;
        time_accum  <= time_accum + time_step;
      end
      if (state == tars_pkg::ST_ROT && step != tars_pkg::RotLast) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  // sine table: sine read in ST_SIN, cosine in ST_COS
  assign rom_angle = (state == tars_pkg::ST_COS) ? (angle_accum + tars_pkg::QuarterTurn)
                                                 : angle_accum;

  tars_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine (
    .clk   (clk),
    .angle (rom_angle),
    .value (rom_value)
  );

  always_ff @(posedge clk) begin
    if (state == tars_pkg::ST_COS) begin
      sin_val <= rom_value;
    end
    if (state == tars_pkg::ST_CWAIT) begin
      cos_val <= rom_value;
    end
  end

  // product t of a copy: vertex t/4, term t%4 of (c*a, -s*b, s*a, c*b)
  assign mul_vtx   = step[3:2];
  assign mul_coord = step[0] ? coord_b : coord_a;
  assign wstep     = step - 4'd1;
  assign wr_vtx    = wstep[3:2];
  assign wr_coord  = wstep[1] ? coord_b : coord_a;
  assign wr_idx    = 4'({wr_vtx, 1'b0}) + 4'(wr_vtx) + 4'(wr_coord);

  always_comb begin
    if (step == tars_pkg::RotLast) begin
      mul_idx = '0;
    end else begin
      mul_idx = 4'({mul_vtx, 1'b0}) + 4'(mul_vtx) + 4'(mul_coord);
    end
  end

  always_comb begin
    case (step[1:0])
      2'd1:    mac_factor = -sin_val;
      2'd2:    mac_factor = sin_val;
      default: mac_factor = cos_val;
    endcase
  end

  assign mac_coord          = held[mul_idx];
  assign mac_ctrl.mul_en    = (state == tars_pkg::ST_ROT) && (step != tars_pkg::RotLast);
  assign mac_ctrl.acc_en    = (state == tars_pkg::ST_ROT) && (step != 4'd0);
  assign mac_ctrl.acc_first = step[0];

  tars_mac #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mac (
    .clk          (clk),
    .ctrl         (mac_ctrl),
    .coord        (mac_coord),
    .factor       (mac_factor),
    .result       (mac_result),
    .result_valid (mac_valid)
  );

  // triangle and result words
  always_ff @(posedge clk) begin
    if (in_take) begin
      held[0] <= v0_x;
      held[1] <= v0_y;
      held[2] <= v0_z;
      held[3] <= v1_x;
      held[4] <= v1_y;
      held[5] <= v1_z;
      held[6] <= v2_x;
      held[7] <= v2_y;
      held[8] <= v2_z;
    end
    if (state == tars_pkg::ST_CWAIT) begin
      for (int v = 0; v < 3; v++) begin
        res[4'(v * 3) + 4'(coord_p)] <= held[4'(v * 3) + 4'(coord_p)];
      end
    end
    if (mac_valid) begin
      res[wr_idx] <= mac_result;
    end
  end

  assign r0_x       = res[0];
  assign r0_y       = res[1];
  assign r0_z       = res[2];
  assign r1_x       = res[3];
  assign r1_y       = res[4];
  assign r1_z       = res[5];
  assign r2_x       = res[6];
  assign r2_y       = res[7];
  assign r2_z       = res[8];
  assign time_value = time_accum;
  assign last_copy  = (copy_index == copies - CW'(1));

  // checks
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a word is pending");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tars_pkg::ST_ROT) |-> (step <= tars_pkg::RotLast))
    else $error("rotation step counter overran");

  a_mac_write_in_rot: assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (state == tars_pkg::ST_ROT) && !step[0] && (step != 4'd0))
    else $error("accumulator result outside rotation pass");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (copy_index < copies))
    else $error("copy index beyond copy count");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (out_take && last_copy) |=> (state == tars_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after last word");

endmodule
`default_nettype wire

>>> tb/rotation_copy_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_copy_checker: scoreboard for the triangle axis rotation sweep
// Tracks the register port, predicts every rotated copy of each triangle
// taken on the input channel and compares the words on the output channel,
// in order, field by field. Reports a failure count and the words still due.
// ----------------------------------------------------------------------------
module rotation_copy_checker (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          cfg_write,
  input  wire logic [1:0]                                    cfg_index,
  input  wire logic [tars_pkg::CfgWidth-1:0]                 cfg_data,
  input  wire logic                                          in_valid,
  input  wire logic                                          in_stall,
  input  wire logic [8:0][tars_pkg::CoordWidth-1:0]          tri_in,
  input  wire logic                                          out_valid,
  input  wire logic                                          out_stall,
  input  wire logic [8:0][tars_pkg::CoordWidth-1:0]          rot_out,
  input  wire logic [tars_pkg::TimeWidth-1:0]                time_value,
  input  wire logic                                          last_copy,
  output int                                                 fail_count,
  output int                                                 pending_words
);
  import tars_pkg::*;

  typedef struct packed {
    logic [8:0][CoordWidth-1:0] coords;
    logic [TimeWidth-1:0]       stamp;
    logic                       last;
  } copy_word_t;

  logic [TabWidth-1:0]   quarter_sine [0:SineTableDepth];
  logic [1:0]            axis_reg;
  logic [CountWidth-1:0] steps_reg;
  logic [AngleWidth-1:0] angle_reg;
  logic [TimeWidth-1:0]  stamp_reg;
  copy_word_t            copies_due [$];
  string coord_name [9] = '{"r0_x", "r0_y", "r0_z", "r1_x", "r1_y", "r1_z",
                            "r2_x", "r2_y", "r2_z"};

  // seven-term series on a Q30 phase, rounded into Q1.15
  function automatic logic [TabWidth-1:0] sine_entry(input int k);
    longint unsigned phase;
    longint unsigned term;
    longint          acc;
    longint          q15;
    phase = (HalfPiQ30 * longint'(k)) / SineTableDepth;
    term  = phase;
    acc   = longint'(phase);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * phase) >> 30) * phase >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q15 = (acc * 32767 + (longint'(1) <<< 29)) / (longint'(1) <<< 30);
    if (q15 > 32767) begin
      q15 = 32767;
    end
    return q15[TabWidth-1:0];
  endfunction

  // quadrant unfolding of the quarter-wave table
  function automatic longint signed_trig(input logic [AngleWidth-1:0] a);
    int     j;
    longint mag;
    j   = (int'(a[13:0]) * SineTableDepth) >> 14;
    mag = a[14] ? longint'(quarter_sine[SineTableDepth - j]) : longint'(quarter_sine[j]);
    return a[15] ? -mag : mag;
  endfunction

  function automatic logic [CoordWidth-1:0] round_clip(input longint acc);
    longint r;
    r = (acc + RoundBias) >>> FracBits;
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return r[CoordWidth-1:0];
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    if (fail_count < 10) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
    fail_count++;
  endtask

  task automatic predict_copies();
    int                    n;
    logic [AngleWidth-1:0] ang;
    logic [TimeWidth-1:0]  stamp_acc;
    longint                s, c, x, y, z;
    copy_word_t            w;
    n = int'(steps_reg);
    if (n < 2) begin
      n = 2;
    end
    if (n > MaxSteps) begin
      n = MaxSteps;
    end
    ang       = '0;
    stamp_acc = '0;
    for (int i = 0; i < n; i++) begin
      s = signed_trig(ang);
      c = signed_trig(ang + QuarterTurn);
      for (int v = 0; v < 3; v++) begin
        x = longint'($signed(tri_in[3 * v + CoordX]));
        y = longint'($signed(tri_in[3 * v + CoordY]));
        z = longint'($signed(tri_in[3 * v + CoordZ]));
        case (axis_reg)
          AxisY: begin
            w.coords[3 * v + CoordX] = round_clip(c * x + s * z);
            w.coords[3 * v + CoordY] = round_clip(y * 32768);
            w.coords[3 * v + CoordZ] = round_clip(c * z - s * x);
          end
          AxisZ: begin
            w.coords[3 * v + CoordX] = round_clip(c * x - s * y);
            w.coords[3 * v + CoordY] = round_clip(s * x + c * y);
            w.coords[3 * v + CoordZ] = round_clip(z * 32768);
          end
          default: begin
            // the spare axis code rotates about x as well
            w.coords[3 * v + CoordX] = round_clip(x * 32768);
            w.coords[3 * v + CoordY] = round_clip(c * y - s * z);
            w.coords[3 * v + CoordZ] = round_clip(s * y + c * z);
          end
        endcase
      end
      w.stamp = stamp_acc;
      w.last  = (i == n - 1);
      copies_due.push_back(w);
      ang       = ang + angle_reg;
      stamp_acc = stamp_acc + stamp_reg;
    end
  endtask

  task automatic match_copy();
    copy_word_t want;
    if (copies_due.size() == 0) begin
      if (fail_count < 10) begin
        $display("%0t: output word with nothing expected", $time);
      end
      fail_count++;
    end else begin
      want = copies_due.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (rot_out[k] !== want.coords[k]) begin
          report_field(coord_name[k], longint'($signed(want.coords[k])),
                       longint'($signed(rot_out[k])));
        end
      end
      if (time_value !== want.stamp) begin
        report_field("time_value", longint'(want.stamp), longint'(time_value));
      end
      if (last_copy !== want.last) begin
        report_field("last_copy", longint'(want.last), longint'(last_copy));
      end
    end
  endtask

  initial begin
    for (int k = 0; k <= SineTableDepth; k++) begin
      quarter_sine[k] = sine_entry(k);
    end
    fail_count    = 0;
    pending_words = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      axis_reg  = AxisReset;
      steps_reg = StepCountReset;
      angle_reg = AngleStepReset;
      stamp_reg = TimeStepReset;
      copies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        match_copy();
      end
      if (in_valid && !in_stall) begin
        predict_copies();
      end
      if (cfg_write) begin
        case (cfg_index)
          CfgAxisSelect: axis_reg  = cfg_data[1:0];
          CfgStepCount:  steps_reg = cfg_data[CountWidth-1:0];
          CfgAngleStep:  angle_reg = cfg_data[AngleWidth-1:0];
          CfgTimeStep:   stamp_reg = cfg_data[TimeWidth-1:0];
          default:       ;
        endcase
      end
    end
    pending_words = copies_due.size();
  end

endmodule

>>> tb/triangle_axis_rotation_sweep_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_axis_rotation_sweep_tb: stimulus and verdict for the rotation sweep
// Directed triangles at the coordinate extremes on every axis and register
// corner, then random triangles under random settings with sender gaps,
// receiver stalls, a long output hold-off and a full drain mid-stream.
// ----------------------------------------------------------------------------
module triangle_axis_rotation_sweep_tb;
  import tars_pkg::*;

  typedef logic [8:0][CoordWidth-1:0] triangle_t;

  localparam logic [1:0] AxisSpare   = 2'd3;
  localparam int         HoldCycles  = 600;
  localparam int         DrainCycles = 48;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = CfgAxisSelect;
  logic [CfgWidth-1:0]   cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  triangle_t             tri_in    = '0;
  logic                  out_stall = 1'b0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   last_copy;
  wire [8:0][CoordWidth-1:0] rot_out;
  wire [TimeWidth-1:0]   time_value;
  int                    fail_count;
  int                    pending_words;
  int                    tx_idle_pct  = 0;
  int                    rx_stall_pct = 0;
  int                    hold_asked   = 0;
  int                    hold_served  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  triangle_axis_rotation_sweep uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .v0_x       (tri_in[0]),
    .v0_y       (tri_in[1]),
    .v0_z       (tri_in[2]),
    .v1_x       (tri_in[3]),
    .v1_y       (tri_in[4]),
    .v1_z       (tri_in[5]),
    .v2_x       (tri_in[6]),
    .v2_y       (tri_in[7]),
    .v2_z       (tri_in[8]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .r0_x       (rot_out[0]),
    .r0_y       (rot_out[1]),
    .r0_z       (rot_out[2]),
    .r1_x       (rot_out[3]),
    .r1_y       (rot_out[4]),
    .r1_z       (rot_out[5]),
    .r2_x       (rot_out[6]),
    .r2_y       (rot_out[7]),
    .r2_z       (rot_out[8]),
    .time_value (time_value),
    .last_copy  (last_copy)
  );

  rotation_copy_checker copy_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .tri_in        (tri_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rot_out       (rot_out),
    .time_value    (time_value),
    .last_copy     (last_copy),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // each vertex takes the three values in a rotated order
  function automatic triangle_t cyclic_tri(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c);
    triangle_t t;
    t[0] = a; t[1] = b; t[2] = c;
    t[3] = b; t[4] = c; t[5] = a;
    t[6] = c; t[7] = a; t[8] = b;
    return t;
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t t;
    for (int k = 0; k < 9; k++) begin
      case ($urandom_range(0, 9))
        0:       t[k] = 16'h8000;
        1:       t[k] = 16'h7FFF;
        2:       t[k] = CoordWidth'($urandom_range(0, 3)) - CoordWidth'(2);
        default: t[k] = CoordWidth'($urandom);
      endcase
    end
    return t;
  endfunction

  // lower valid and wait until every predicted word has left the block
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgWidth-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic set_config(input logic [CfgWidth-1:0] axis_word,
                            input logic [CfgWidth-1:0] step_word,
                            input logic [CfgWidth-1:0] angle_word,
                            input logic [CfgWidth-1:0] stamp_word);
    drain();
    write_reg(CfgAxisSelect, axis_word);
    write_reg(CfgStepCount, step_word);
    write_reg(CfgAngleStep, angle_word);
    write_reg(CfgTimeStep, stamp_word);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_config();
    logic [CfgWidth-1:0] axis_word;
    logic [CfgWidth-1:0] step_word;
    logic [CfgWidth-1:0] angle_word;
    logic [CfgWidth-1:0] stamp_word;
    int                  pick;
    axis_word  = CfgWidth'($urandom);
    step_word  = CfgWidth'($urandom);
    angle_word = CfgWidth'($urandom);
    stamp_word = CfgWidth'($urandom);
    pick = $urandom_range(0, 15);
    // mostly short sweeps, now and then the longest or a raw out-of-range count
    if (pick == 0) begin
      step_word[CountWidth-1:0] = CountWidth'(MaxSteps);
    end else if (pick > 1) begin
      step_word[CountWidth-1:0] = CountWidth'($urandom_range(2, 8));
    end
    if ($urandom_range(0, 7) == 0) begin
      angle_word = CfgWidth'($urandom_range(0, 3) << 14);
    end
    set_config(axis_word, step_word, angle_word, stamp_word);
  endtask

  task automatic offer_triangle(input triangle_t t);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    tri_in   <= t;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        repeat (HoldCycles) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        hold_served++;
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults straight out of reset
    offer_triangle(cyclic_tri(16'h7FFF, 16'h8000, 16'h0000));
    offer_triangle(cyclic_tri(16'h1234, 16'hFFFB, 16'h4000));

    // eighth turns about z push the sums past full scale, time wraps
    set_config({14'h0, AxisZ}, 16'd8, 16'h2000, 16'hFFFF);
    offer_triangle(cyclic_tri(16'h7FFF, 16'h7FFF, 16'h7FFF));
    offer_triangle(cyclic_tri(16'h8000, 16'h8000, 16'h8000));
    offer_triangle(cyclic_tri(16'h7FFF, 16'h8000, 16'h0001));
    offer_triangle(cyclic_tri(16'h0000, 16'h0000, 16'h0000));

    // zero angle shows the unit-scale shrink, a count of one is raised to two
    set_config({14'h3FFE, AxisY}, {9'h1FF, 7'd1}, 16'h0000, 16'h0001);
    offer_triangle(cyclic_tri(16'h7FFF, 16'h8000, 16'h7FFF));
    offer_triangle(cyclic_tri(16'h8000, 16'h7FFF, 16'h8000));
    offer_triangle(cyclic_tri(16'h0001, 16'hFFFF, 16'h0002));

    // spare axis code, count of zero, largest angle step
    set_config({14'h0, AxisSpare}, {9'h0, 7'd0}, 16'hFFFF, 16'h8000);
    offer_triangle(cyclic_tri(16'h8000, 16'h7FFF, 16'h0000));
    offer_triangle(cyclic_tri(16'h5A5A, 16'hA5A5, 16'hFFFF));
    offer_triangle(cyclic_tri(16'h7FFF, 16'h7FFF, 16'h8000));

    // count above the maximum, quarter turns about x
    set_config({14'h0, AxisX}, {9'h0, 7'd127}, 16'h4000, 16'h1234);
    offer_triangle(cyclic_tri(16'h7FFF, 16'h8000, 16'h3FFF));
    offer_triangle(cyclic_tri(16'hC000, 16'h4000, 16'h8001));

    set_config({14'h0, AxisY}, {9'h0, 7'd64}, 16'h0001, 16'h0007);
    offer_triangle(cyclic_tri(16'h7FFF, 16'h8000, 16'h7FFF));

    set_config({14'h0, AxisZ}, {9'h0, 7'd2}, 16'h8000, 16'h0000);
    offer_triangle(cyclic_tri(16'h8000, 16'h8000, 16'h7FFF));
    offer_triangle(cyclic_tri(16'h7FFF, 16'h0000, 16'h8000));

    set_config({14'h0, AxisY}, {9'h0, 7'd65}, 16'hC000, 16'h0003);
    offer_triangle(cyclic_tri(16'h8000, 16'h0001, 16'h7FFF));

    for (int mode = 0; mode < 4; mode++) begin
      for (int sub = 0; sub < 8; sub++) begin
        random_config();
        case (mode)
          0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1:       begin tx_idle_pct = 55; rx_stall_pct = 0;  end
          2:       begin tx_idle_pct = 0;  rx_stall_pct = 55; end
          default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
        endcase
        // long output hold-off while words keep coming, so the block backs up
        if (mode == 0 && sub == 1) begin
          hold_asked++;
        end
        for (int k = 0; k < 14; k++) begin
          if (mode == 1 && sub == 3 && k == 7) begin
            drain();
          end
          offer_triangle(random_triangle());
        end
      end
    end

    drain();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> triangle_axis_rotation_sweep.f
hdl/tars_pkg.sv
hdl/tars_sine_rom.sv
hdl/tars_mac.sv
hdl/triangle_axis_rotation_sweep.sv
tb/rotation_copy_checker.sv
tb/triangle_axis_rotation_sweep_tb.sv
